[hw/rtl/cplt_pkg.sv]
// ----------------------------------------------------------------------------
// cplt_pkg
// Shared types, sizes and codes for the convex polygon lattice test block.
// ----------------------------------------------------------------------------
package cplt_pkg;

	// Vertex store depth.
	localparam int MAX_VERTICES = 16;

	// Vertex store address width.
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	// Width of the vertex count in use (3..MAX_VERTICES).
	localparam int N_W    = $clog2(MAX_VERTICES + 1);
	// Width of the scan counter (0..MAX_VERTICES+1).
	localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
	// Width of the configuration register.
	localparam int CFG_W  = 5;
	// Reset value of the configuration register.
	localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(4);
	// Smallest vertex count in use.
	localparam int MIN_VERTICES = 3;

	// Operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [3:0]         vertex_index;
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [11:0] point_x;
		logic signed [11:0] point_y;
	} item_t;

	typedef struct packed {
		logic               inside_res;
		logic signed [11:0] box_min_x;
		logic signed [11:0] box_max_x;
		logic signed [11:0] box_min_y;
		logic signed [11:0] box_max_y;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the accepted item, clear the edge verdict
		logic issue;    // a vertex read was issued this cycle
		logic first;    // the read is vertex 0 (start of box)
		logic in_box;   // the read belongs to the box sweep
		logic edge_chk; // the read completes an edge window
		logic publish;  // load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic drained;  // no read or edge still in flight
	} dp_status_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} ctrl_state_t;

endpackage

[hw/rtl/cplt_ram.sv]
// ----------------------------------------------------------------------------
// cplt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cplt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/cplt_ctrl.sv]
// ----------------------------------------------------------------------------
// cplt_ctrl
// Sequencer: accepts an item, sweeps the vertex store, waits for the datapath
// to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module cplt_ctrl
	import cplt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              operation,
	input  logic [3:0]        vertex_index,
	input  logic [N_W-1:0]    n_use,
	output logic              ram_we,
	output logic              ram_re,
	output logic [VIDX_W-1:0] ram_raddr,
	output dp_cmd_t           cmd,
	input  dp_status_t        status,
	output logic              result_valid,
	input  logic              result_stall
);

	ctrl_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             result_valid_q;
	logic             accept;
	logic             publish;
	logic [CNT_W-1:0] last_cnt;
	logic [CNT_W-1:0] n_ext;

	assign n_ext    = CNT_W'(n_use);
	assign last_cnt = n_ext + CNT_W'(1);
	assign accept   = (state_q == S_IDLE) && item_valid;
	assign publish  = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

	// Write a vertex on an accepted load; drop indexes beyond the store.
	assign ram_we = accept && (operation == OP_LOAD) && (int'(vertex_index) < MAX_VERTICES);

	// Read vertices 0..n-1, then 0 and 1 again to close the edges from vertex n-2 and from vertex n-1.
	assign ram_re    = (state_q == S_SCAN);
	assign ram_raddr = (cnt_q < n_ext) ? VIDX_W'(cnt_q) : VIDX_W'(cnt_q - n_ext);

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.issue    = ram_re;
		cmd.first    = ram_re && (cnt_q == '0);
		cmd.in_box   = ram_re && (cnt_q < n_ext);
		cmd.edge_chk = ram_re && (cnt_q >= CNT_W'(2));
		cmd.publish  = publish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == last_cnt) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DRAIN: begin
					if (status.drained) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (publish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (publish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/cplt_dp.sv]
// ----------------------------------------------------------------------------
// cplt_dp
// Datapath: three-vertex window, cross-product sign test per edge, running
// bounding box and result register.
// ----------------------------------------------------------------------------
module cplt_dp
	import cplt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  item_t       item,
	input  logic [31:0] rdata,
	output dp_status_t  status,
	output result_t     result
);

	// Captured item
	logic               op_q;
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;

	// Tag pipeline
	logic v_s1, first_s1, box_s1, edge_s1;
	logic edge_s2;
	logic edge_s3;

	// Vertex window: w0 = vertex k, w1 = k+1, w2 = k+2
	logic signed [15:0] w0x_q, w0y_q, w1x_q, w1y_q, w2x_q, w2y_q;
	logic signed [15:0] rx, ry;

	// Box
	logic signed [15:0] lox_q, hix_q, loy_q, hiy_q;

	// Edge arithmetic
	logic signed [16:0] ex, ey, dxr, dyr, dxp, dyp;
	logic signed [33:0] mul_a, mul_b, mul_c, mul_d;
	logic signed [33:0] pa_s3, pb_s3, pc_s3, pd_s3;
	logic signed [34:0] cref, cpt;
	logic               fail_q;
	logic               edge_fail;

	// Floor of Q11.4, minus one, clamped at the grid edge.
	function automatic logic [11:0] box_lo(input logic [15:0] v);
		logic [12:0] d;
		d = {v[15], v[15:4]} - 13'd1;
		return (d[12] != d[11]) ? 12'h800 : d[11:0];
	endfunction

	// Floor of Q11.4, plus one, clamped at the grid edge.
	function automatic logic [11:0] box_hi(input logic [15:0] v);
		logic [12:0] d;
		d = {v[15], v[15:4]} + 13'd1;
		return (d[12] != d[11]) ? 12'h7FF : d[11:0];
	endfunction

	assign rx = rdata[31:16];
	assign ry = rdata[15:0];

	assign ex  = {w1x_q[15], w1x_q} - {w0x_q[15], w0x_q};
	assign ey  = {w1y_q[15], w1y_q} - {w0y_q[15], w0y_q};
	assign dxr = {w2x_q[15], w2x_q} - {w0x_q[15], w0x_q};
	assign dyr = {w2y_q[15], w2y_q} - {w0y_q[15], w0y_q};
	assign dxp = {px_q[15], px_q} - {w0x_q[15], w0x_q};
	assign dyp = {py_q[15], py_q} - {w0y_q[15], w0y_q};

	assign mul_a = ex * dyr;
	assign mul_b = ey * dxr;
	assign mul_c = ex * dyp;
	assign mul_d = ey * dxp;

	assign cref = {pa_s3[33], pa_s3} - {pb_s3[33], pb_s3};
	assign cpt  = {pc_s3[33], pc_s3} - {pd_s3[33], pd_s3};

	// Reject when both sides are nonzero and of opposite sign.
	assign edge_fail = (cref != '0) && (cpt != '0) && (cref[34] != cpt[34]);

	assign status.drained = !(v_s1 || edge_s2 || edge_s3);

	// Control tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			box_s1   <= 1'b0;
			edge_s1  <= 1'b0;
			edge_s2  <= 1'b0;
			edge_s3  <= 1'b0;
			fail_q   <= 1'b0;
		end else begin
			v_s1     <= cmd.issue;
			first_s1 <= cmd.first;
			box_s1   <= cmd.in_box;
			edge_s1  <= cmd.edge_chk;
			edge_s2  <= v_s1 && edge_s1;
			edge_s3  <= edge_s2;
			if (cmd.capture) begin
				fail_q <= 1'b0;
			end else if (edge_s3 && edge_fail) begin
				fail_q <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= item.operation;
			px_q <= {item.point_x, 4'b0000};
			py_q <= {item.point_y, 4'b0000};
		end

		if (v_s1) begin
			w0x_q <= w1x_q;
			w0y_q <= w1y_q;
			w1x_q <= w2x_q;
			w1y_q <= w2y_q;
			w2x_q <= rx;
			w2y_q <= ry;
		end

		if (v_s1 && box_s1) begin
			if (first_s1) begin
				lox_q <= rx;
				hix_q <= rx;
				loy_q <= ry;
				hiy_q <= ry;
			end else begin
				if (rx < lox_q) lox_q <= rx;
				if (rx > hix_q) hix_q <= rx;
				if (ry < loy_q) loy_q <= ry;
				if (ry > hiy_q) hiy_q <= ry;
			end
		end

		if (edge_s2) begin
			pa_s3 <= mul_a;
			pb_s3 <= mul_b;
			pc_s3 <= mul_c;
			pd_s3 <= mul_d;
		end

		if (cmd.publish) begin
			result.inside_res <= (op_q == OP_TEST) && !fail_q;
			result.box_min_x  <= box_lo(lox_q);
			result.box_max_x  <= box_hi(hix_q);
			result.box_min_y  <= box_lo(loy_q);
			result.box_max_y  <= box_hi(hiy_q);
		end
	end

endmodule

[hw/rtl/convex_polygon_lattice_test_top.sv]
// ----------------------------------------------------------------------------
// convex_polygon_lattice_test_top
// Point in convex polygon test on an integer grid, with a bounding box.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Beat
// item      in   item_valid/stall     item_t: load vertex or test point
// result    out  result_valid/stall   result_t: inside flag and box
// cfg       in   cfg_valid/ready      vertex count in use (5 bits)
//
// Every item is accepted, then n + 2 reads of the vertex store are made, n
// being the vertex count in use (3..16), the read and edge pipeline drains
// and the result is published. The vertex store has a single read port,
// one vertex per cycle; the next item is accepted only after the publish.
// Reset clears the controller, the count register (to 4) and the result
// valid flag; the vertex store holds garbage until loaded.
// A stalled result holds in the output register while the next item is
// accepted and swept; only its publish waits on the stall.
//
module convex_polygon_lattice_test_top
	import cplt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0]  vcount_q;
	logic [N_W-1:0]    n_use;
	logic              ram_we;
	logic              ram_re;
	logic [VIDX_W-1:0] ram_raddr;
	logic [31:0]       ram_rdata;
	dp_cmd_t           cmd;
	dp_status_t        status;

	// Always take configuration; the user must write it only while the block is idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	// Saturate the count in use to 3..MAX_VERTICES.
	always_comb begin
		priority if (int'(vcount_q) < MIN_VERTICES) begin
			n_use = N_W'(MIN_VERTICES);
		end else if (int'(vcount_q) > MAX_VERTICES) begin
			n_use = N_W'(MAX_VERTICES);
		end else begin
			n_use = N_W'(vcount_q);
		end
	end

	// Vertex store: x in the upper half, y in the lower half.
	cplt_ram #(
		.WIDTH(32),
		.DEPTH(MAX_VERTICES)
	) u_vstore (
		.clk  (clk),
		.we   (ram_we),
		.waddr(VIDX_W'(item.vertex_index)),
		.wdata({item.vertex_x, item.vertex_y}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cplt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (item.operation),
		.vertex_index(item.vertex_index),
		.n_use       (n_use),
		.ram_we      (ram_we),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	cplt_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.item  (item),
		.rdata (ram_rdata),
		.status(status),
		.result(result)
	);

	// Reads stay inside the vertices in use.
	a_raddr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (N_W'(ram_raddr) < n_use))
		else $error("vertex read beyond count in use");

	// The store is written only in the accept cycle, never during a sweep.
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (item_valid && !item_stall && !ram_re))
		else $error("vertex write outside accept");

	// An accepted item closes the input and starts the sweep; the input stays closed until its result is published.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (item_stall && ram_re))
		else $error("input not held off after accept");

	// A result is published only when the datapath pipeline is empty.
	a_publish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> status.drained)
		else $error("publish with edges in flight");

endmodule
